>>> design/bfpa_pkg.sv
// shared constants, codes and types of the best-fit pool allocator
package bfpa_pkg;

  localparam int POOL_BYTES   = 128;
  localparam int HEADER_BYTES = 8;
  localparam int FREE_ENTRIES = 16;

  localparam int ADDR_W = $clog2(POOL_BYTES);
  localparam int IDX_W  = $clog2(FREE_ENTRIES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int LEN_W  = 8;
  localparam int NEED_W = LEN_W + 1;
  localparam int STAT_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic              command;
    logic [LEN_W-1:0]  request_size;
    logic [ADDR_W-1:0] user_address;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  free_entry_count;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted_address;
  } res_t;

  typedef struct packed {
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] length;
  } ent_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ent_t             wr_data;
  } tbl_port_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [LEN_W-1:0]  wr_data;
  } hdr_port_t;

endpackage

>>> design/bfpa_ram.sv
// generic single-write, single-read ram with registered read data
module bfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/bfpa_seq.sv
// sequencer: best-fit scan, carve, compaction and free append over the two rams
module bfpa_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  bfpa_pkg::req_t                 req,
  output logic                           idle,
  output logic                           res_valid,
  output bfpa_pkg::res_t                 res,
  input  logic                           res_ready,
  output bfpa_pkg::tbl_port_t            tbl,
  input  bfpa_pkg::ent_t                 tbl_rd_data,
  output bfpa_pkg::hdr_port_t            hdr,
  input  logic [bfpa_pkg::LEN_W-1:0]     hdr_rd_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_CARVE   = 3'd2;
  localparam logic [2:0] S_SHIFT   = 3'd3;
  localparam logic [2:0] S_FREE_RD = 3'd4;
  localparam logic [2:0] S_FREE_WR = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]                       state_r, state_nxt;
  logic [bfpa_pkg::NEED_W-1:0]      need_r, need_nxt;
  logic [bfpa_pkg::ADDR_W-1:0]      base_r, base_nxt;
  logic [bfpa_pkg::CNT_W-1:0]       idx_r, idx_nxt;
  logic                             pend_r, pend_nxt;
  logic [bfpa_pkg::IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic                             found_r, found_nxt;
  logic [bfpa_pkg::IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [bfpa_pkg::LEN_W-1:0]       best_len_r, best_len_nxt;
  logic [bfpa_pkg::LEN_W-1:0]       best_base_r, best_base_nxt;
  logic [bfpa_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [bfpa_pkg::ADDR_W-1:0]      granted_r, granted_nxt;
  logic [bfpa_pkg::STAT_W-1:0]      status_r, status_nxt;
  logic                             init_r, init_nxt;
  logic                             rd0_r, rd0_nxt;
  logic                             issue;
  bfpa_pkg::ent_t                   ent;

  // entry zero holds the whole pool until first written
  always_comb begin
    if (init_r && rd0_r) begin
      ent.base   = '0;
      ent.length = bfpa_pkg::LEN_W'(bfpa_pkg::POOL_BYTES);
    end else begin
      ent = tbl_rd_data;
    end
  end

  assign issue = (idx_r < count_r);

  always_comb begin
    state_nxt     = state_r;
    need_nxt      = need_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_len_nxt  = best_len_r;
    best_base_nxt = best_base_r;
    count_nxt     = count_r;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    tbl           = '0;
    hdr           = '0;
    res_valid     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          need_nxt    = {1'b0, req.request_size} + bfpa_pkg::NEED_W'(bfpa_pkg::HEADER_BYTES);
          base_nxt    = req.user_address - bfpa_pkg::ADDR_W'(bfpa_pkg::HEADER_BYTES);
          idx_nxt     = '0;
          pend_nxt    = 1'b0;
          found_nxt   = 1'b0;
          granted_nxt = '0;
          status_nxt  = bfpa_pkg::STAT_OK;
          if (req.command == bfpa_pkg::CMD_ALLOC) begin
            if (req.request_size == '0) begin
              status_nxt = bfpa_pkg::STAT_ZERO;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (count_r == bfpa_pkg::CNT_W'(bfpa_pkg::FREE_ENTRIES)) begin
            status_nxt = bfpa_pkg::STAT_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_FREE_RD;
          end
        end
      end
      S_SCAN: begin
        tbl.rd_en    = issue;
        tbl.rd_addr  = idx_r[bfpa_pkg::IDX_W-1:0];
        pend_nxt     = issue;
        pend_idx_nxt = idx_r[bfpa_pkg::IDX_W-1:0];
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        // strict less keeps the lowest index among equal lengths
        if (pend_r && ({1'b0, ent.length} >= need_r) &&
            (!found_r || ent.length < best_len_r)) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = pend_idx_r;
          best_len_nxt  = ent.length;
          best_base_nxt = ent.base;
        end
        if (!issue && !pend_r) begin
          if (found_r) begin
            state_nxt = S_CARVE;
          end else begin
            status_nxt = bfpa_pkg::STAT_NOFIT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_CARVE: begin
        tbl.wr_en          = 1'b1;
        tbl.wr_addr        = best_idx_r;
        tbl.wr_data.base   = best_base_r + need_r[bfpa_pkg::LEN_W-1:0];
        tbl.wr_data.length = best_len_r - need_r[bfpa_pkg::LEN_W-1:0];
        hdr.wr_en          = 1'b1;
        hdr.wr_addr        = best_base_r[bfpa_pkg::ADDR_W-1:0];
        hdr.wr_data        = need_r[bfpa_pkg::LEN_W-1:0];
        granted_nxt        = best_base_r[bfpa_pkg::ADDR_W-1:0] +
                             bfpa_pkg::ADDR_W'(bfpa_pkg::HEADER_BYTES);
        if (best_len_r == need_r[bfpa_pkg::LEN_W-1:0]) begin
          idx_nxt   = {1'b0, best_idx_r} + 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        // move each later entry down by one
        tbl.rd_en    = issue;
        tbl.rd_addr  = idx_r[bfpa_pkg::IDX_W-1:0];
        pend_nxt     = issue;
        pend_idx_nxt = idx_r[bfpa_pkg::IDX_W-1:0];
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pend_r) begin
          tbl.wr_en   = 1'b1;
          tbl.wr_addr = pend_idx_r - 1'b1;
          tbl.wr_data = ent;
        end
        if (!issue && !pend_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_FREE_RD: begin
        hdr.rd_en   = 1'b1;
        hdr.rd_addr = base_r;
        state_nxt   = S_FREE_WR;
      end
      S_FREE_WR: begin
        tbl.wr_en          = 1'b1;
        tbl.wr_addr        = count_r[bfpa_pkg::IDX_W-1:0];
        tbl.wr_data.base   = bfpa_pkg::LEN_W'(base_r);
        tbl.wr_data.length = hdr_rd_data;
        if (hdr_rd_data != '0) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    init_nxt = init_r;
    if (tbl.wr_en && tbl.wr_addr == '0) begin
      init_nxt = 1'b0;
    end
    rd0_nxt = rd0_r;
    if (tbl.rd_en) begin
      rd0_nxt = (tbl.rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= bfpa_pkg::CNT_W'(1);
      init_r  <= 1'b1;
      pend_r  <= 1'b0;
      rd0_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      init_r  <= init_nxt;
      pend_r  <= pend_nxt;
      rd0_r   <= rd0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r      <= need_nxt;
    base_r      <= base_nxt;
    idx_r       <= idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_len_r  <= best_len_nxt;
    best_base_r <= best_base_nxt;
    granted_r   <= granted_nxt;
    status_r    <= status_nxt;
  end

  assign idle                 = (state_r == S_IDLE);
  assign res.granted_address  = granted_r;
  assign res.status           = status_r;
  assign res.free_entry_count = count_r;

endmodule

>>> design/best_fit_pool_allocator_unit.sv
// top level of the best-fit pool allocator: rams, sequencer and result register
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tdata: request_size[7:0], user_address[14:8], pad[15]
//                                    tuser: command (0 alloc, 1 free)
// out_     out  out_tvalid/out_tready tdata: granted_address[6:0], status[8:7],
//                                    free_entry_count[13:9], pad[15:14]
//
// one request at a time; the free table ram has one read port, so the best-fit
// scan reads one entry a cycle; an alloc then carves the best entry, and when that
// entry empties the later entries shift down
// a free reads the header ram, then appends; zero size or full go straight to the result
// reset is synchronous; the free table reads as one whole-pool entry after reset
// a waiting word in the result register does not block the next request until
// the sequencer has a new word ready for it
module best_fit_pool_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // request_size, user_address, zero pad
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // granted_address, status, free_entry_count, zero pad
);

  bfpa_pkg::req_t                 req;
  bfpa_pkg::res_t                 seq_res;
  bfpa_pkg::res_t                 out_data_r;
  bfpa_pkg::tbl_port_t            tbl;
  bfpa_pkg::hdr_port_t            hdr;
  bfpa_pkg::ent_t                 tbl_rd_ent;
  logic [$bits(bfpa_pkg::ent_t)-1:0] tbl_rd_raw;
  logic [bfpa_pkg::LEN_W-1:0]     hdr_rd_data;
  logic                           seq_idle;
  logic                           seq_valid;
  logic                           res_ready;
  logic                           start;
  logic                           out_valid_r, out_valid_nxt;

  // input word unpack
  assign req.command      = in_tuser;
  assign req.request_size = in_tdata[7:0];
  assign req.user_address = in_tdata[14:8];

  assign in_tready = seq_idle;
  assign start     = in_tvalid && in_tready;

  // free table: {base, length} per entry
  bfpa_ram #(
    .WIDTH ($bits(bfpa_pkg::ent_t)),
    .DEPTH (bfpa_pkg::FREE_ENTRIES)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl.wr_en),
    .wr_addr (tbl.wr_addr),
    .wr_data (tbl.wr_data),
    .rd_en   (tbl.rd_en),
    .rd_addr (tbl.rd_addr),
    .rd_data (tbl_rd_raw)
  );

  assign tbl_rd_ent = tbl_rd_raw;

  // header store: block size at each block base
  bfpa_ram #(
    .WIDTH (bfpa_pkg::LEN_W),
    .DEPTH (bfpa_pkg::POOL_BYTES)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (hdr.wr_en),
    .wr_addr (hdr.wr_addr),
    .wr_data (hdr.wr_data),
    .rd_en   (hdr.rd_en),
    .rd_addr (hdr.rd_addr),
    .rd_data (hdr_rd_data)
  );

  bfpa_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .req         (req),
    .idle        (seq_idle),
    .res_valid   (seq_valid),
    .res         (seq_res),
    .res_ready   (res_ready),
    .tbl         (tbl),
    .tbl_rd_data (tbl_rd_ent),
    .hdr         (hdr),
    .hdr_rd_data (hdr_rd_data)
  );

  // result register: takes a new word once the old one is gone or leaving
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = seq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_valid && res_ready) begin
      out_data_r <= seq_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

  // the table never reports more entries than it holds
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[13:9] <= 5'(bfpa_pkg::FREE_ENTRIES)))
    else $error("free entry count beyond table depth");

  // only a successful alloc or a free carries status ok; refusals grant nothing
  a_refused_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8:7] != bfpa_pkg::STAT_OK) |-> (out_tdata[6:0] == '0))
    else $error("address granted on a refused request");

  // the sequencer is no longer idle once a request is accepted, so in_tready drops
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one still in work");

endmodule

>>> tb/sv/best_fit_pool_allocator_unit_test.sv
// testbench of the best-fit pool allocator: request drivers, allocator scoreboard, result checks
module best_fit_pool_allocator_unit_test;
  import bfpa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 430;
  localparam int IDLE_PCT     = 11;

  // tracks the free table and header store, predicts and checks every result word
  class pool_ledger;
    logic [LEN_W-1:0] base_tab[FREE_ENTRIES];
    logic [LEN_W-1:0] len_tab[FREE_ENTRIES];
    int               n_entries;
    logic [LEN_W-1:0] hdr_size[POOL_BYTES];
    bit               hdr_set[POOL_BYTES];
    res_t             grants_due[$];
    int               words_seen;
    int               mismatches;
    int               peak_entries;
    int               stat_seen[4];

    function new();
      foreach (base_tab[i]) begin
        base_tab[i] = '0;
        len_tab[i]  = '0;
      end
      foreach (hdr_size[i]) begin
        hdr_size[i] = '0;
        hdr_set[i]  = 1'b0;
      end
      len_tab[0]   = LEN_W'(POOL_BYTES);
      n_entries    = 1;
      peak_entries = 1;
      words_seen   = 0;
      mismatches   = 0;
      foreach (stat_seen[i]) stat_seen[i] = 0;
    endfunction

    // drop zero-length entries, keep order
    function void squeeze();
      int w;
      int r;
      w = 0;
      for (r = 0; r < n_entries; r++) begin
        if (len_tab[r] != 0) begin
          base_tab[w] = base_tab[r];
          len_tab[w]  = len_tab[r];
          w++;
        end
      end
      n_entries = w;
    endfunction

    function int widest();
      int w;
      int i;
      w = 0;
      for (i = 0; i < n_entries; i++) if (int'(len_tab[i]) > w) w = int'(len_tab[i]);
      return w;
    endfunction

    function res_t note_request(req_t rq);
      res_t              ex;
      int                best;
      int                i;
      logic [NEED_W-1:0] need;
      logic [LEN_W-1:0]  b;
      logic [ADDR_W-1:0] a;
      ex = '0;
      ex.status = STAT_OK;
      if (rq.command == CMD_ALLOC) begin
        if (rq.request_size == 0) begin
          ex.status = STAT_ZERO;
        end else begin
          need = NEED_W'(rq.request_size) + NEED_W'(HEADER_BYTES);
          best = -1;
          // smallest fitting entry, lowest index on ties
          for (i = 0; i < n_entries; i++) begin
            if (NEED_W'(len_tab[i]) >= need && (best < 0 || len_tab[i] < len_tab[best]))
              best = i;
          end
          if (best < 0) begin
            ex.status = STAT_NOFIT;
          end else begin
            b = base_tab[best];
            hdr_size[b[ADDR_W-1:0]] = need[LEN_W-1:0];
            hdr_set[b[ADDR_W-1:0]]  = 1'b1;
            ex.granted_address = b[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
            base_tab[best] = b + need[LEN_W-1:0];
            len_tab[best]  = len_tab[best] - need[LEN_W-1:0];
            squeeze();
          end
        end
      end else begin
        if (n_entries >= FREE_ENTRIES) begin
          ex.status = STAT_FULL;
        end else begin
          // header sits just below the user address, wrapping in the pool
          a = rq.user_address - ADDR_W'(HEADER_BYTES);
          base_tab[n_entries] = LEN_W'(a);
          len_tab[n_entries]  = hdr_size[a];
          n_entries++;
          squeeze();
        end
      end
      ex.free_entry_count = CNT_W'(n_entries);
      if (n_entries > peak_entries) peak_entries = n_entries;
      stat_seen[ex.status]++;
      grants_due.push_back(ex);
      return ex;
    endfunction

    function void miss(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on word %0d: %s expected %0d got %0d", words_seen, what, want, got);
    endfunction

    function void check_word(logic [15:0] word);
      res_t ex;
      words_seen++;
      if (grants_due.size() == 0) begin
        miss("word with nothing outstanding, tdata", 0, int'(word));
        return;
      end
      ex = grants_due.pop_front();
      if (word[6:0] !== ex.granted_address)
        miss("granted_address", int'(ex.granted_address), int'(word[6:0]));
      if (word[8:7] !== ex.status)
        miss("status", int'(ex.status), int'(word[8:7]));
      if (word[13:9] !== ex.free_entry_count)
        miss("free_entry_count", int'(ex.free_entry_count), int'(word[13:9]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // request_size, user_address, zero pad
  logic        in_tuser = 1'b0; // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // granted_address, status, free_entry_count, zero pad

  pool_ledger            ledger;
  logic [ADDR_W-1:0]     held[$];     // user addresses of blocks still owned
  bit                    calm = 1'b0; // no idling on either side while set
  int                    stray_frees = 0;
  int                    cycles = 0;

  best_fit_pool_allocator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               ledger.grants_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic req_t make_req(logic cmd, int sz, int ua);
    req_t rq;
    rq.command      = cmd;
    rq.request_size = LEN_W'(sz);
    rq.user_address = ADDR_W'(ua);
    return rq;
  endfunction

  // hold one request on the bus until it is taken, then predict it
  task automatic offer(input req_t rq);
    res_t ex;
    in_tvalid <= 1'b1;
    in_tuser  <= rq.command;
    in_tdata  <= {1'b0, rq.user_address, rq.request_size};
    do @(posedge clk); while (in_tready !== 1'b1);
    ex = ledger.note_request(rq);
    if (rq.command == CMD_ALLOC && ex.status == STAT_OK) held.push_back(ex.granted_address);
    // a refused free leaves the block owned
    if (rq.command == CMD_FREE && ex.status == STAT_FULL) held.push_back(rq.user_address);
  endtask

  // mostly alloc/free of owned blocks, with exact fits, repeat frees and odd sizes mixed in
  function automatic req_t pick_request();
    req_t rq;
    int   roll;
    int   wide;
    int   cap;
    int   k;
    int   i;
    int   spots[$];
    rq = make_req(CMD_ALLOC, $urandom_range(128), $urandom_range(127));
    roll = $urandom_range(99);
    wide = ledger.widest();
    if (roll < 45) begin
      if (wide > HEADER_BYTES) begin
        if ($urandom_range(4) == 0) begin
          // exact fit empties an entry and forces a shift
          k = $urandom_range(ledger.n_entries - 1);
          if (ledger.len_tab[k] > HEADER_BYTES)
            rq.request_size = LEN_W'(ledger.len_tab[k] - HEADER_BYTES);
        end else begin
          cap = wide - HEADER_BYTES;
          if ($urandom_range(2) != 0 && cap > 24) cap = 24;
          rq.request_size = LEN_W'($urandom_range(cap, 1));
        end
      end
    end else if (roll < 90) begin
      if (held.size() != 0 && roll < 84) begin
        k = $urandom_range(held.size() - 1);
        rq.command      = CMD_FREE;
        rq.user_address = held[k];
        held.delete(k);
      end else begin
        // free again a block whose header was written at some point
        for (i = 0; i < POOL_BYTES; i++) if (ledger.hdr_set[i]) spots.push_back(i);
        if (spots.size() != 0) begin
          rq.command      = CMD_FREE;
          rq.user_address = ADDR_W'(spots[$urandom_range(spots.size() - 1)] + HEADER_BYTES);
          stray_frees++;
        end
      end
    end else begin
      case ($urandom_range(2))
        0: rq.request_size = '0;
        1: rq.request_size = LEN_W'($urandom_range(128, 121));
        default: ;
      endcase
    end
    return rq;
  endfunction

  // result side: random back-pressure plus one long hold-off
  initial begin
    int  hold;
    bit  held_off;
    hold = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) ledger.check_word(out_tdata);
      if (!held_off && ledger.words_seen == 60) begin
        held_off = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // request side
  initial begin
    int n;
    int i;
    ledger = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero size, too large, whole pool, empty table
    offer(make_req(CMD_ALLOC, 0, 127));
    offer(make_req(CMD_ALLOC, 121, 0));
    offer(make_req(CMD_ALLOC, 120, 0));
    offer(make_req(CMD_ALLOC, 1, 127));
    // give the pool back, then carve a small block
    offer(make_req(CMD_FREE, 128, 8));
    offer(make_req(CMD_ALLOC, 1, 0));
    // repeated frees of one block fill the table with equal entries, last one is refused
    for (i = 0; i < 16; i++) offer(make_req(CMD_FREE, 0, 8));
    offer(make_req(CMD_ALLOC, 128, 85));
    // tie among equal lengths, exact fit removes an entry
    offer(make_req(CMD_ALLOC, 1, 42));
    offer(make_req(CMD_ALLOC, 111, 0));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) begin
        // sender pause until the block has drained
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (ledger.grants_due.size() != 0) @(posedge clk);
      end
      calm = (n >= 250 && n < 330);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      offer(pick_request());
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (ledger.grants_due.size() != 0) @(posedge clk);
    // catch any stray word after the last expected one
    repeat (60) @(posedge clk);

    $display("requests %0d, words %0d: ok %0d, zero size %0d, no fit %0d, table full %0d",
             ledger.stat_seen[0] + ledger.stat_seen[1] + ledger.stat_seen[2] +
             ledger.stat_seen[3], ledger.words_seen, ledger.stat_seen[STAT_OK],
             ledger.stat_seen[STAT_ZERO], ledger.stat_seen[STAT_NOFIT],
             ledger.stat_seen[STAT_FULL]);
    $display("peak free entries %0d, repeat frees %0d, mismatches %0d, left over %0d",
             ledger.peak_entries, stray_frees, ledger.mismatches, ledger.grants_due.size());
    if (ledger.mismatches == 0 && ledger.grants_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
